[src/bbt_pkg.sv]
// Shared types and constants of the block buffer tag table.
package bbt_pkg;

    localparam int OP_W    = 2;
    localparam int BLK_W   = 16;
    localparam int ST_W    = 2;
    localparam int SLOT_W  = 5;
    localparam int WB_W    = 13;
    localparam int AGE_W   = 6;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;
    localparam int OUT_PAD = OUT_W - (ST_W + SLOT_W + 1 + WB_W + SLOT_W);

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
    localparam logic [OP_W-1:0] OP_DIRTY  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_MISS  = 2'd2;

    typedef struct packed {
        logic             hit;
        logic             older;
        logic [AGE_W-1:0] aged;
    } t_cmp;

endpackage

[src/bbt_ram.sv]
// Tag and stamp memory: one write port, one registered read port.
module bbt_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 19
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[src/bbt_cmp.sv]
// Shared compare unit: tag match, saturating stamp increment and oldest test.
module bbt_cmp #(
    parameter int TAG_W = 13
) (
    input  logic                      i_used,
    input  logic [TAG_W-1:0]          i_tag,
    input  logic [bbt_pkg::AGE_W-1:0] i_age,
    input  logic [TAG_W-1:0]          i_key,
    input  logic [bbt_pkg::AGE_W-1:0] i_best,
    output bbt_pkg::t_cmp             o_res
);
    import bbt_pkg::*;

    logic [AGE_W-1:0] aged;

    always_comb begin
        aged        = (i_age == AGE_MAX) ? i_age : i_age + AGE_W'(1);
        o_res.hit   = i_used && (i_tag == i_key);
        o_res.aged  = aged;
        o_res.older = i_used && (aged > i_best);
    end

endmodule

[src/block_buffer_tag_table.sv]
// Top level of the block buffer tag table: sequencer, slot flags and result register.
// Lookup and set-dirty raise their result at the end of the slot scan; allocate first goes on through S_VRD and S_VWB.
// Out-of-range block numbers and opcode 3 raise their result at the edge that takes the word.
// One word at a time: the input is ready again in the cycle after the result is taken. The
// scan is set by the single read port of the tag and stamp RAM, scanned one slot per cycle.
// Synchronous active-low reset clears the used and dirty flags at once; no clearing pass.
module block_buffer_tag_table #(
    parameter int SLOTS     = 32,
    parameter int DISK_SIZE = 8192
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // opcode [1:0], block_num [17:2], zero [23:18]
    input  logic [bbt_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status [1:0], slot_index [6:2], writeback_valid [7], writeback_block_num [20:8],
    // writeback_slot [25:21], zero [31:26]
    output logic [bbt_pkg::OUT_W-1:0]  m_axis_tdata
);
    import bbt_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int TAG_W = $clog2(DISK_SIZE);
    localparam int ENT_W = TAG_W + AGE_W;
    localparam int LIM_W = BLK_W + 1;
    localparam logic [LIM_W-1:0] DISK_LIM = LIM_W'(DISK_SIZE);
    localparam logic [IDX_W-1:0] LAST     = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_VRD, S_VWB, S_OUT} t_state;

    t_state             r_state;
    logic [OP_W-1:0]    r_op;
    logic [TAG_W-1:0]   r_blk;
    logic [IDX_W-1:0]   r_idx;
    logic               r_issue;
    logic               r_vld;
    logic [IDX_W-1:0]   r_cidx;
    logic               r_found;
    logic [IDX_W-1:0]   r_fidx;
    logic [AGE_W-1:0]   r_best_age;
    logic [IDX_W-1:0]   r_bidx;
    logic [SLOTS-1:0]   r_used;
    logic [SLOTS-1:0]   r_dirty;
    logic               r_tvalid;
    logic [ST_W-1:0]    r_status;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_wbv;
    logic [WB_W-1:0]    r_wbblk;
    logic [SLOT_W-1:0]  r_wbslot;

    logic [OP_W-1:0]    in_op;
    logic [BLK_W-1:0]   in_blk;
    logic [IDX_W-1:0]   victim;
    logic [IDX_W-1:0]   idx_now;
    logic               hit_now;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENT_W-1:0]   wdata;
    logic [IDX_W-1:0]   raddr;
    logic [ENT_W-1:0]   rdata;
    logic [TAG_W-1:0]   q_tag;
    logic [AGE_W-1:0]   q_age;
    t_cmp               cmp;

    assign in_op   = s_axis_tdata[OP_W-1:0];
    assign in_blk  = s_axis_tdata[OP_W+BLK_W-1:OP_W];
    assign victim  = r_found ? r_fidx : r_bidx;
    assign hit_now = r_found || cmp.hit;
    assign idx_now = r_found ? r_fidx : r_cidx;
    assign q_tag   = rdata[ENT_W-1:AGE_W];
    assign q_age   = rdata[AGE_W-1:0];
    assign raddr   = (r_state == S_VRD) ? victim : r_idx;

    always_comb begin
        we    = 1'b0;
        waddr = r_cidx;
        wdata = {q_tag, cmp.aged};
        if (r_state == S_VWB) begin
            we    = 1'b1;
            waddr = victim;
            wdata = {r_blk, {AGE_W{1'b0}}};
        end else if (r_state == S_SCAN && r_vld && r_op == OP_ALLOC && r_used[r_cidx]) begin
            we = 1'b1;
        end
    end

    bbt_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    bbt_cmp #(
        .TAG_W (TAG_W)
    ) u_cmp (
        .i_used (r_used[r_cidx]),
        .i_tag  (q_tag),
        .i_age  (q_age),
        .i_key  (r_blk),
        .i_best (r_best_age),
        .o_res  (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_dirty  <= '0;
            r_tvalid <= 1'b0;
            r_issue  <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op       <= in_op;
                        r_blk      <= in_blk[TAG_W-1:0];
                        r_slot     <= '0;
                        r_wbv      <= 1'b0;
                        r_wbblk    <= '0;
                        r_wbslot   <= '0;
                        r_found    <= 1'b0;
                        r_fidx     <= '0;
                        r_best_age <= '0;
                        r_bidx     <= '0;
                        r_idx      <= '0;
                        r_status   <= ST_OK;
                        if (in_op == OP_NOP) begin
                            r_tvalid <= 1'b1;
                            r_state  <= S_OUT;
                        end else if ({1'b0, in_blk} >= DISK_LIM) begin
                            r_status <= ST_RANGE;
                            r_tvalid <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_vld  <= r_issue;
                    r_cidx <= r_idx;
                    if (r_issue) begin
                        r_idx <= r_idx + IDX_W'(1);
                        if (r_idx == LAST) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_vld) begin
                        if (r_op == OP_ALLOC) begin
                            if (!r_used[r_cidx] && !r_found) begin
                                r_found <= 1'b1;
                                r_fidx  <= r_cidx;
                            end
                            if (cmp.older) begin
                                r_best_age <= cmp.aged;
                                r_bidx     <= r_cidx;
                            end
                            if (r_cidx == LAST) begin
                                r_state <= S_VRD;
                            end
                        end else begin
                            if (cmp.hit && !r_found) begin
                                r_found <= 1'b1;
                                r_fidx  <= r_cidx;
                            end
                            if (r_cidx == LAST) begin
                                r_tvalid <= 1'b1;
                                r_state  <= S_OUT;
                                if (hit_now) begin
                                    r_slot <= SLOT_W'(idx_now);
                                    if (r_op == OP_DIRTY) begin
                                        r_dirty[idx_now] <= 1'b1;
                                    end
                                end else begin
                                    r_status <= ST_MISS;
                                end
                            end
                        end
                    end
                end
                S_VRD: begin
                    r_state <= S_VWB;
                end
                S_VWB: begin
                    if (!r_found && r_dirty[victim]) begin
                        r_wbv    <= 1'b1;
                        r_wbblk  <= WB_W'(q_tag);
                        r_wbslot <= SLOT_W'(victim);
                    end
                    r_used[victim]  <= 1'b1;
                    r_dirty[victim] <= 1'b0;
                    r_slot          <= SLOT_W'(victim);
                    r_tvalid        <= 1'b1;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_tvalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, r_wbslot, r_wbblk, r_wbv, r_slot, r_status};

endmodule

[src/bbt_chk.sv]
// Port checker of the block buffer tag table and its binding.
module bbt_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [bbt_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [bbt_pkg::OUT_W-1:0] m_axis_tdata
);
    import bbt_pkg::*;

    logic [ST_W-1:0]   st;
    logic [SLOT_W-1:0] slot;
    logic              wbv;

    assign st   = m_axis_tdata[ST_W-1:0];
    assign slot = m_axis_tdata[ST_W+SLOT_W-1:ST_W];
    assign wbv  = m_axis_tdata[ST_W+SLOT_W];

    // hold off new words while one is in flight
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word taken while another is in flight");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while a result waits");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
        else $error("not idle after result taken");

    a_err_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st != ST_OK |-> slot == '0 && !wbv)
        else $error("slot or write-back set on a failed operation");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> st == ST_OK || st == ST_RANGE || st == ST_MISS)
        else $error("status code out of range");

    logic unused_in;
    assign unused_in = ^s_axis_tdata;

endmodule

bind block_buffer_tag_table bbt_chk u_bbt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/block_buffer_tag_table_chk.sv]
// Checker for the block buffer tag table: predicts every result word and compares it.
module block_buffer_tag_table_chk #(
    parameter int SLOTS     = 32,
    parameter int DISK_SIZE = 8192
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [bbt_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [bbt_pkg::OUT_W-1:0] i_m_tdata,
    output int                        o_errors,
    output int                        o_pending
);

    import bbt_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [SLOT_W-1:0] slot;
        logic              wb_valid;
        logic [WB_W-1:0]   wb_blk;
        logic [SLOT_W-1:0] wb_slot;
    } t_tag_result;

    logic              slot_used [SLOTS];
    logic              slot_dirty[SLOTS];
    logic [WB_W-1:0]   slot_tag  [SLOTS];
    logic [AGE_W-1:0]  slot_age  [SLOTS];
    t_tag_result       awaited_results[$];
    int                fail_count = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic t_tag_result table_response(input logic [OP_W-1:0] op,
                                                   input logic [BLK_W-1:0] blk);
        t_tag_result r;
        int          hit;
        int          victim;
        int          best;
        r      = '0;
        hit    = -1;
        victim = -1;
        best   = -1;
        if (op != OP_NOP) begin
            if (blk >= DISK_SIZE) begin
                r.status = ST_RANGE;
            end else if (op == OP_LOOKUP || op == OP_DIRTY) begin
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_used[i] && slot_tag[i] == blk[WB_W-1:0])
                        hit = i;
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.slot = hit[SLOT_W-1:0];
                    if (op == OP_DIRTY)
                        slot_dirty[hit] = 1'b1;
                end
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i] && slot_age[i] < AGE_MAX)
                        slot_age[i] = slot_age[i] + 1'b1;
                for (int i = 0; i < SLOTS; i++)
                    if (victim < 0 && !slot_used[i])
                        victim = i;
                if (victim < 0) begin
                    victim = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (int'(slot_age[i]) > best) begin
                            best   = int'(slot_age[i]);
                            victim = i;
                        end
                    end
                    if (slot_dirty[victim]) begin
                        r.wb_valid = 1'b1;
                        r.wb_blk   = slot_tag[victim];
                        r.wb_slot  = victim[SLOT_W-1:0];
                    end
                end
                slot_used[victim]  = 1'b1;
                slot_dirty[victim] = 1'b0;
                slot_tag[victim]   = blk[WB_W-1:0];
                slot_age[victim]   = '0;
                r.slot             = victim[SLOT_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_tag_result want;
        t_tag_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i]  = 1'b0;
                slot_dirty[i] = 1'b0;
                slot_tag[i]   = '0;
                slot_age[i]   = '0;
            end
            awaited_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(table_response(i_s_tdata[OP_W-1:0],
                                                         i_s_tdata[OP_W +: BLK_W]));
            if (i_m_tvalid && i_m_tready) begin
                got.status   = i_m_tdata[ST_W-1:0];
                got.slot     = i_m_tdata[ST_W +: SLOT_W];
                got.wb_valid = i_m_tdata[ST_W+SLOT_W];
                got.wb_blk   = i_m_tdata[ST_W+SLOT_W+1 +: WB_W];
                got.wb_slot  = i_m_tdata[ST_W+SLOT_W+1+WB_W +: SLOT_W];
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word %h", i_m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.wb_valid !== want.wb_valid || got.wb_blk !== want.wb_blk ||
                        got.wb_slot !== want.wb_slot) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: status %0d/%0d slot %0d/%0d wb %0d/%0d %s",
                                     want.status, got.status, want.slot, got.slot,
                                     want.wb_valid, got.wb_valid,
                                     $sformatf("wb_blk %0d/%0d wb_slot %0d/%0d (exp/act)",
                                               want.wb_blk, got.wb_blk,
                                               want.wb_slot, got.wb_slot));
                    end
                end
            end
        end
        o_errors  <= fail_count;
        o_pending <= awaited_results.size();
    end

endmodule

[tb/block_buffer_tag_table_tb.sv]
// Testbench top for the block buffer tag table: stimulus, idling and verdict.
module block_buffer_tag_table_tb;

    import bbt_pkg::*;

    localparam int SLOTS      = 32;
    localparam int DISK_SIZE  = 8192;
    localparam int POOL       = 48;
    localparam int CYCLE_CAP  = 200000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // opcode [1:0], block_num [17:2], zero [23:18]
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // status [1:0], slot_index [6:2], writeback_valid [7], writeback_block_num [20:8],
    // writeback_slot [25:21], zero [31:26]
    logic [OUT_W-1:0]  m_axis_tdata;

    int                errors;
    int                pending;
    int                cycles = 0;
    int                stall_left = 0;
    bit                idle_on = 1'b1;
    logic [BLK_W-1:0]  block_pool[POOL];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    block_buffer_tag_table #(
        .SLOTS     (SLOTS),
        .DISK_SIZE (DISK_SIZE)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    block_buffer_tag_table_chk #(
        .SLOTS     (SLOTS),
        .DISK_SIZE (DISK_SIZE)
    ) u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold off the result side in short random bursts.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-OP_W-BLK_W){1'b0}}, blk, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int               r;
        logic [OP_W-1:0]  op;
        logic [BLK_W-1:0] blk;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_rst_n       <= 1'b0;
        block_pool[0] = '0;
        block_pool[1] = BLK_W'(DISK_SIZE - 1);
        for (int i = 2; i < POOL; i++)
            block_pool[i] = BLK_W'($urandom_range(0, DISK_SIZE - 1));
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_LOOKUP, 16'd0);
        send_word(OP_DIRTY,  16'd8191);
        send_word(OP_LOOKUP, 16'd8192);
        send_word(OP_ALLOC,  16'hFFFF);
        send_word(OP_DIRTY,  16'hAAAA);
        send_word(OP_LOOKUP, 16'h5555);
        send_word(OP_NOP,    16'hFFFF);
        send_word(OP_NOP,    16'h5555);
        send_word(OP_ALLOC,  16'd0);
        send_word(OP_ALLOC,  16'd8191);
        send_word(OP_ALLOC,  16'd0);
        send_word(OP_LOOKUP, 16'd0);
        send_word(OP_DIRTY,  16'd0);
        send_word(OP_DIRTY,  16'd8191);
        send_word(OP_LOOKUP, 16'd8191);
        send_word(OP_ALLOC,  16'd8192);
        send_word(OP_LOOKUP, 16'h1555);
        send_word(OP_ALLOC,  16'h1555);
        send_word(OP_ALLOC,  16'h0AAA);
        send_word(OP_DIRTY,  16'h0AAA);
        send_word(OP_LOOKUP, 16'h1555);

        for (int n = 0; n < 500; n++) begin
            if (n == 250)
                wait_drained();
            if (n == 400)
                idle_on = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 4) begin
                op  = OP_NOP;
                blk = BLK_W'($urandom);
            end else if (r < 7) begin
                op  = OP_W'($urandom_range(0, 2));
                blk = BLK_W'($urandom_range(DISK_SIZE, 65535));
            end else if (r < 10) begin
                op  = OP_W'($urandom_range(0, 2));
                blk = BLK_W'($urandom);
            end else begin
                if (r < 55)
                    op = OP_ALLOC;
                else if (r < 78)
                    op = OP_LOOKUP;
                else
                    op = OP_DIRTY;
                if ($urandom_range(0, 9) == 0)
                    blk = BLK_W'($urandom_range(0, DISK_SIZE - 1));
                else
                    blk = block_pool[$urandom_range(0, POOL - 1)];
            end
            send_word(op, blk);
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
